@@ rtl/dds_pkg.sv @@
// shared types and constants of the decimal digit sorter
`timescale 1ns / 1ps
`default_nettype none
package dds_pkg;
	localparam int VALUE_W  = 32;
	localparam int DIGIT_W  = 5;
	localparam int NUM_BINS = 10;
	localparam int BIN_W    = 4;
	// most digits a 32-bit value can have
	localparam int RESULT_CAP = 10;
	// reciprocal of ten: q = (x * RECIP10) >> RECIP_SHIFT for any 32-bit x
	localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	typedef logic [VALUE_W-1:0]        mag_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [DIGIT_W-1:0] digit_t;
	typedef logic [BIN_W-1:0]          bin_idx_t;
endpackage
`default_nettype wire

@@ rtl/dds_if.sv @@
// valid/ready channels for input and result words
`timescale 1ns / 1ps
`default_nettype none
interface dds_in_if;
	logic            valid;
	logic            ready;
	dds_pkg::value_t value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface dds_out_if;
	logic            valid;
	logic            ready;
	dds_pkg::digit_t digit;
	logic            last;
	modport source (output valid, output digit, output last, input ready);
	modport sink   (input valid, input digit, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/dds_div10.sv @@
// shared divide-by-ten unit: registered reciprocal multiply, then remainder
`timescale 1ns / 1ps
`default_nettype none
module dds_div10 (
	input  wire logic              clk,
	input  wire dds_pkg::mag_t     x,
	output dds_pkg::mag_t          quot,
	output dds_pkg::bin_idx_t      rem
);
	logic [2*dds_pkg::VALUE_W-1:0] prod_s1;
	dds_pkg::mag_t                 x_s1;
	dds_pkg::mag_t                 quot10;
	dds_pkg::mag_t                 diff;

	always_ff @(posedge clk) begin
		prod_s1 <= {{dds_pkg::VALUE_W{1'b0}}, x} * {{dds_pkg::VALUE_W{1'b0}}, dds_pkg::RECIP10};
		x_s1    <= x;
	end

	// quotient * 10 as two shifted copies
	assign quot   = dds_pkg::VALUE_W'(prod_s1 >> dds_pkg::RECIP_SHIFT);
	assign quot10 = (quot << 3) + (quot << 1);
	assign diff   = x_s1 - quot10;
	assign rem    = diff[dds_pkg::BIN_W-1:0];
endmodule
`default_nettype wire

@@ rtl/decimal_digit_sorter.sv @@
// top level of the decimal digit sorter
`timescale 1ns / 1ps
`default_nettype none
// Takes one signed 32-bit word and returns its decimal digits in ascending
// order, one result word per digit, with last set on the final one; a zero
// input gives no result words. Digits of a negative input are truncated
// remainders in -9..0. Only the MAX_DIGITS lowest-order digits are kept
// (never more than ten). The input is taken when the block is idle;
// each digit then passes through the shared divide-by-ten unit, first in
// the multiply state and then in the remainder state.
// The digits are counted into ten bins, and emission walks the bins in
// order, skipping each empty bin and sending one digit per cycle while the
// output register can take it. The output register lets the next input
// word be taken while the final result word still waits to be read.
module decimal_digit_sorter #(
	parameter int MAX_DIGITS = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dds_in_if.sink     item,
	dds_out_if.source  result
);
	// effective digit cap and width of the per-bin counts
	localparam int LIMIT = (MAX_DIGITS > dds_pkg::RESULT_CAP) ? dds_pkg::RESULT_CAP : MAX_DIGITS;
	localparam int CNT_W = $clog2(LIMIT + 1);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_REM  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]          state_q;
	dds_pkg::mag_t       mag_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    left_q;
	logic [CNT_W-1:0]    bin_q [dds_pkg::NUM_BINS];
	dds_pkg::bin_idx_t   rank_q;
	logic                out_valid_q;
	dds_pkg::digit_t     out_digit_q;
	logic                out_last_q;

	dds_pkg::mag_t       in_mag;
	dds_pkg::mag_t       quot;
	dds_pkg::bin_idx_t   rem;
	dds_pkg::bin_idx_t   sel_bin;
	logic [CNT_W-1:0]    cnt_nxt;
	logic                slot_free;
	logic                in_fire;
	logic                emit_fire;

	// magnitude of the input; the most negative value maps to 2^31 exactly
	assign in_mag = item.value[dds_pkg::VALUE_W-1] ? (~item.value + 1'b1) : item.value;

	assign item.ready = (state_q == ST_IDLE);
	assign in_fire    = item.valid && item.ready;

	// shared divider works on the running quotient
	dds_div10 u_div10 (
		.clk  (clk),
		.x    (mag_q),
		.quot (quot),
		.rem  (rem)
	);

	assign cnt_nxt = cnt_q + 1'b1;

	// ascending order: small magnitudes first when positive, large when negative
	assign sel_bin = neg_q ? (dds_pkg::bin_idx_t'(dds_pkg::NUM_BINS - 1) - rank_q) : rank_q;

	// output register can take a word when empty or being drained
	assign slot_free = !out_valid_q || result.ready;

	// a digit moves into the output register this cycle
	assign emit_fire = (state_q == ST_EMIT) && (bin_q[sel_bin] != '0) && slot_free;

	assign result.valid = out_valid_q;
	assign result.digit = out_digit_q;
	assign result.last  = out_last_q;

	// control and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (item.value != '0)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					// stop when the quotient runs out or the cap is hit
					if ((quot == '0) || (cnt_nxt == CNT_W'(LIMIT))) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (emit_fire && (left_q == CNT_W'(1))) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: running quotient, digit bins, emission walk, output word
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					mag_q  <= in_mag;
					neg_q  <= item.value[dds_pkg::VALUE_W-1];
					cnt_q  <= '0;
					rank_q <= '0;
					for (int b = 0; b < dds_pkg::NUM_BINS; b++) begin
						bin_q[b] <= '0;
					end
				end
			end
			ST_MUL: begin
			end
			ST_REM: begin
				bin_q[rem] <= bin_q[rem] + 1'b1;
				mag_q      <= quot;
				cnt_q      <= cnt_nxt;
				left_q     <= cnt_nxt;
			end
			ST_EMIT: begin
				if (bin_q[sel_bin] == '0) begin
					rank_q <= rank_q + 1'b1;
				end else if (slot_free) begin
					bin_q[sel_bin] <= bin_q[sel_bin] - 1'b1;
					left_q         <= left_q - 1'b1;
					out_last_q     <= (left_q == CNT_W'(1));
					out_digit_q    <= neg_q ? -dds_pkg::digit_t'({1'b0, sel_bin})
					                        : dds_pkg::digit_t'({1'b0, sel_bin});
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

@@ tb/sv/decimal_digit_sorter_test.sv @@
// self-checking testbench of the decimal digit sorter
`timescale 1ns / 1ps
module decimal_digit_sorter_test;
	// digit limit the block is built with; ten is the most a 32-bit word can have
	localparam int DIGIT_LIMIT   = 10;
	// wait after the last owed digit, long enough to cover the drain of a ten-digit word
	localparam int SETTLE_CYCLES = 60;
	// a quiet stretch is at most a long send gap, one item's work and a long stall
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_WORDS  = 270;
	localparam int STEADY_WORDS  = 30;

	typedef struct {
		int digit;
		bit last;
	} sorted_digit_t;

	logic clk;
	logic arst_n;

	dds_in_if  item_bus ();
	dds_out_if result_bus ();

	decimal_digit_sorter #(
		.MAX_DIGITS(DIGIT_LIMIT)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.result(result_bus)
	);

	// digits still owed by the block, oldest first
	sorted_digit_t digits_due[$];

	// when set, neither side idles, giving back-to-back traffic
	bit steady;

	int fail_count;
	int words_sent;
	int zero_words;
	int negative_words;
	int digits_checked;
	int quiet_cycles;
	int stall_left;

	always #5 clk = ~clk;

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		item_bus.valid     = 1'b0;
		item_bus.value     = '0;
		result_bus.ready   = 1'b0;
		steady             = 1'b0;
		fail_count         = 0;
		words_sent         = 0;
		zero_words         = 0;
		negative_words     = 0;
		digits_checked     = 0;
		quiet_cycles       = 0;
		stall_left         = 0;
	end

	// ---------------------------------------------------------------------
	// expected digits of one input word
	// ---------------------------------------------------------------------

	// split by truncating division (sign follows the input, as in C), keep at
	// most the digit limit of low-order digits, then order them ascending
	function automatic void queue_sorted_digits(input dds_pkg::value_t word);
		int rest;
		int keep;
		int count;
		int found[dds_pkg::RESULT_CAP];
		int key;
		int j;
		sorted_digit_t entry;
		rest  = word;
		keep  = (DIGIT_LIMIT < dds_pkg::RESULT_CAP) ? DIGIT_LIMIT : dds_pkg::RESULT_CAP;
		count = 0;
		while (rest != 0 && count < keep) begin
			found[count] = rest % 10;
			rest         = rest / 10;
			count++;
		end
		// insertion sort keeps equal digits in order
		for (int i = 1; i < count; i++) begin
			key = found[i];
			j   = i - 1;
			while (j >= 0 && found[j] > key) begin
				found[j + 1] = found[j];
				j--;
			end
			found[j + 1] = key;
		end
		for (int i = 0; i < count; i++) begin
			entry.digit = found[i];
			entry.last  = (i == count - 1);
			digits_due.push_back(entry);
		end
	endfunction

	// ---------------------------------------------------------------------
	// monitors: input acceptance, result checking, watchdog
	// ---------------------------------------------------------------------

	// every accepted input word adds its digits to the expected store
	always @(posedge clk) begin
		if (arst_n && item_bus.valid && item_bus.ready) begin
			queue_sorted_digits(item_bus.value);
			words_sent++;
			if (item_bus.value == 0)
				zero_words++;
			if (item_bus.value < 0)
				negative_words++;
		end
	end

	// each result word is checked field by field against the oldest expectation
	always @(posedge clk) begin
		sorted_digit_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (digits_due.size() == 0) begin
				$display("%0t: unexpected result word, digit %0d last %0b", $time,
					int'(result_bus.digit), result_bus.last);
				fail_count++;
			end else begin
				want = digits_due.pop_front();
				digits_checked++;
				if (int'(result_bus.digit) != want.digit) begin
					$display("%0t: digit mismatch, expected %0d, actual %0d", $time,
						want.digit, int'(result_bus.digit));
					fail_count++;
				end
				if (result_bus.last !== want.last) begin
					$display("%0t: last mismatch, expected %0b, actual %0b", $time,
						want.last, result_bus.last);
					fail_count++;
				end
			end
		end
	end

	// ends a hung run: counts cycles in which no word moves on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_bus.valid && item_bus.ready) ||
				(result_bus.valid && result_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, no word moved for %0d cycles, %0d digits owed",
					$time, QUIET_LIMIT, digits_due.size());
				$display("decimal_digit_sorter_test NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// result side back-pressure
	// ---------------------------------------------------------------------

	// mostly ready; stalls are usually short, now and then long
	always @(posedge clk) begin
		if (!arst_n || steady) begin
			result_bus.ready <= arst_n;
			stall_left       <= 0;
		end else if (stall_left > 0) begin
			result_bus.ready <= 1'b0;
			stall_left       <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			result_bus.ready <= 1'b0;
			stall_left       <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
			                                                : $urandom_range(0, 2);
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// sender
	// ---------------------------------------------------------------------

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// offers one word and returns at the edge where it is taken; valid stays
	// high so that the next call can follow without a gap
	task automatic send_word(input dds_pkg::value_t word);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			item_bus.value <= dds_pkg::value_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.value <= word;
		do
			@(posedge clk);
		while (!item_bus.ready);
	endtask

	task automatic hold_sender();
		item_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_all_digits();
		while (digits_due.size() != 0)
			@(posedge clk);
	endtask

	// a word of the given number of decimal digits and random sign
	function automatic dds_pkg::value_t word_of_width(input int width);
		longint lo;
		longint hi;
		dds_pkg::value_t mag;
		lo = 1;
		for (int i = 1; i < width; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (width == 1)
			lo = 1;
		if (hi > 64'sd2147483647)
			hi = 64'sd2147483647;
		mag = dds_pkg::value_t'($urandom_range(int'(hi), int'(lo)));
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	task automatic reset_block();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// field extremes, zero, single digits, repeated digits and the most
	// negative word, whose magnitude does not fit in a signed 32-bit word
	task automatic test_edge_words();
		dds_pkg::value_t picks[$];
		picks = '{
			dds_pkg::value_t'(0), dds_pkg::value_t'(1), dds_pkg::value_t'(-1),
			dds_pkg::value_t'(9), dds_pkg::value_t'(-9),
			dds_pkg::value_t'(10), dds_pkg::value_t'(-10),
			dds_pkg::value_t'(100), dds_pkg::value_t'(-100),
			dds_pkg::value_t'(32'h7FFF_FFFF), dds_pkg::value_t'(32'h8000_0000),
			dds_pkg::value_t'(32'h8000_0001),
			dds_pkg::value_t'(1234567890), dds_pkg::value_t'(-1234567890),
			dds_pkg::value_t'(1000000000), dds_pkg::value_t'(1111111111),
			dds_pkg::value_t'(-999999999), dds_pkg::value_t'(987654321),
			dds_pkg::value_t'(3030), dds_pkg::value_t'(0), dds_pkg::value_t'(-5),
			dds_pkg::value_t'(32'h5555_5555), dds_pkg::value_t'(32'hAAAA_AAAA),
			dds_pkg::value_t'(32'hFFFF_FFF6)
		};
		foreach (picks[i])
			send_word(picks[i]);
	endtask

	// the sender stops until every owed digit is out, then starts again
	task automatic test_sender_pause();
		repeat (3)
			send_word(word_of_width(10));
		hold_sender();
		wait_all_digits();
		repeat (3)
			send_word(word_of_width($urandom_range(1, 10)));
	endtask

	// mostly words of random width, some raw 32-bit patterns and zeros
	task automatic test_random_words();
		int roll;
		repeat (RANDOM_WORDS) begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				send_word(dds_pkg::value_t'(0));
			else if (roll < 30)
				send_word(dds_pkg::value_t'($urandom));
			else
				send_word(word_of_width($urandom_range(1, 10)));
		end
	endtask

	// back-to-back words with no idling on either side
	task automatic test_steady_stream();
		hold_sender();
		wait_all_digits();
		steady = 1'b1;
		repeat (STEADY_WORDS)
			send_word(word_of_width($urandom_range(1, 10)));
		hold_sender();
		wait_all_digits();
		steady = 1'b0;
	endtask

	initial begin
		reset_block();
		test_edge_words();
		test_sender_pause();
		test_random_words();
		test_steady_stream();
		hold_sender();
		wait_all_digits();
		// let any stray result word show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (digits_due.size() != 0) begin
			$display("%0t: %0d expected digits never arrived", $time, digits_due.size());
			fail_count++;
		end
		$display("covered %0d input words (%0d zero, %0d negative), %0d digits checked",
			words_sent, zero_words, negative_words, digits_checked);
		$display("with random gaps and stalls, a drained pause and a steady stream");
		if (fail_count == 0)
			$display("decimal_digit_sorter_test OK");
		else
			$display("decimal_digit_sorter_test NOT OK");
		$finish;
	end
endmodule
